>>> rtl/bmd_pkg.sv
// ----------------------------------------------------------------------------
// Battery meter display package
// Shared constants, the stage payload type and the digit helpers used by the
// seven-segment battery meter pipeline.
// ----------------------------------------------------------------------------
package bmd_pkg;

   // Field widths of the item channels.
   localparam int unsigned READING_W = 16;
   localparam int unsigned STATUS_W  = 8;
   localparam int unsigned DISPLAY_W = 29;

   // Status bit that selects percent mode.
   localparam int unsigned MODE_BIT = 4;

   // Millivolt offset of the empty cell and the percent ceiling.
   localparam logic [13:0] MV_OFFSET = 14'd3000;
   localparam logic [6:0]  PCT_MAX   = 7'd100;
   localparam logic [6:0]  PCT_TEN   = 7'd10;

   // Rounding added before the volts digits are taken.
   localparam logic [14:0] MV_ROUND = 15'd5;

   // Level bar cutoffs in percent.
   localparam logic [6:0] BAR_CUT_1 = 7'd5;
   localparam logic [6:0] BAR_CUT_2 = 7'd29;
   localparam logic [6:0] BAR_CUT_3 = 7'd49;
   localparam logic [6:0] BAR_CUT_4 = 7'd69;
   localparam logic [6:0] BAR_CUT_5 = 7'd89;

   // Bit positions inside the display word.
   localparam int unsigned PCT_MARK_POS = 0;
   localparam int unsigned VOLT_MARK_POS = 1;
   localparam int unsigned POINT_POS    = 2;
   localparam int unsigned DIGIT_R_POS  = 3;
   localparam int unsigned DIGIT_M_POS  = 10;
   localparam int unsigned DIGIT_L_POS  = 17;
   localparam int unsigned BAR_POS      = 24;

   // Reciprocal of ten: x / 10 == (x * 52429) >> 19 for every 16-bit x.
   localparam logic [31:0] RECIP_TEN = 32'd52429;
   localparam int unsigned RECIP_SHIFT = 19;

   // Payload carried between the pipeline stages.
   typedef struct packed {
      logic        neg;        // reading was negative
      logic        pct_mode;   // percent mode selected
      logic [6:0]  pct;        // clamped percent, 0..100
      logic [14:0] vr;         // millivolts plus rounding, 0..16388
      logic [10:0] q1;         // vr / 10
      logic [7:0]  q2;         // vr / 100
      logic [4:0]  q3;         // vr / 1000
      logic [3:0]  d_tens;     // tens digit of vr
      logic [3:0]  p_tens;     // tens digit of pct
      logic [3:0]  p_ones;     // ones digit of pct
   } stage_type;

   // Quotient by ten through the reciprocal multiply.
   function automatic logic [15:0] div10(input logic [15:0] x);
      logic [31:0] prod;
      prod = {16'd0, x} * RECIP_TEN;
      return 16'(prod[31:RECIP_SHIFT]);
   endfunction

   // Times ten as shift and add.
   function automatic logic [15:0] mul10(input logic [15:0] x);
      return (x << 3) + (x << 1);
   endfunction

   // Seven-segment pattern of one decimal digit, segment a in bit 0.
   function automatic logic [6:0] seg(input logic [3:0] d);
      logic [6:0] pat;
      unique case (d)
         4'd0:    pat = 7'b0111111;
         4'd1:    pat = 7'b0000110;
         4'd2:    pat = 7'b1011011;
         4'd3:    pat = 7'b1001111;
         4'd4:    pat = 7'b1100110;
         4'd5:    pat = 7'b1101101;
         4'd6:    pat = 7'b1111101;
         4'd7:    pat = 7'b0000111;
         4'd8:    pat = 7'b1111111;
         4'd9:    pat = 7'b1101111;
         default: pat = 7'b0000000;
      endcase
      return pat;
   endfunction

   // Thermometer mask of the level bars for a given percent.
   function automatic logic [4:0] bar_mask(input logic [6:0] pct);
      logic [4:0] m;
      priority if (pct < BAR_CUT_1)  m = 5'b00000;
      else if (pct <= BAR_CUT_2)     m = 5'b00001;
      else if (pct <= BAR_CUT_3)     m = 5'b00011;
      else if (pct <= BAR_CUT_4)     m = 5'b00111;
      else if (pct <= BAR_CUT_5)     m = 5'b01111;
      else                           m = 5'b11111;
      return m;
   endfunction

endpackage

>>> rtl/bmd_if.sv
// ----------------------------------------------------------------------------
// Battery meter display channels
// Valid/ready item channels for the voltage readings and the display words.
// ----------------------------------------------------------------------------

// Reading channel: one signed reading and one status byte per item.
interface bmd_req_if
   import bmd_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic signed [READING_W-1:0] voltage_reading;
   logic [STATUS_W-1:0]         status_bits;

   modport source (output valid, output voltage_reading, output status_bits, input ready);
   modport sink   (input valid, input voltage_reading, input status_bits, output ready);
endinterface

// Display channel: one display word and an error flag per item.
interface bmd_rsp_if
   import bmd_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [DISPLAY_W-1:0] display_bits;
   logic                 error;

   modport source (output valid, output display_bits, output error, input ready);
   modport sink   (input valid, input display_bits, input error, output ready);
endinterface

>>> rtl/bmd_front.sv
// ----------------------------------------------------------------------------
// Battery meter front stage
// Registers an incoming reading as millivolts plus rounding and as a clamped
// percent, together with the sign and the display mode.
// ----------------------------------------------------------------------------
module bmd_front
   import bmd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   bmd_req_if.sink      req_chan,
   output logic         out_valid,
   input  logic         out_ready,
   output stage_type    out_data
);

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;
   logic      advance;
   logic [13:0] mv;
   logic [13:0] diff;
   logic [10:0] pct_raw;

   // The stage moves when it is empty or its item is being taken.
   assign advance        = !valid_ff || out_ready;
   assign req_chan.ready = advance;

   // Millivolts and clamped percent of the reading.
   always_comb begin
      mv      = req_chan.voltage_reading[14:1];
      diff    = mv - MV_OFFSET;
      pct_raw = diff[13:3];
      data_in = '0;
      data_in.neg      = req_chan.voltage_reading[READING_W-1];
      data_in.pct_mode = req_chan.status_bits[MODE_BIT];
      data_in.vr       = {1'b0, mv} + MV_ROUND;
      if (mv < MV_OFFSET) begin
         data_in.pct = '0;
      end else if (pct_raw > 11'(PCT_MAX)) begin
         data_in.pct = PCT_MAX;
      end else begin
         data_in.pct = pct_raw[6:0];
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_chan.valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/bmd_digits.sv
// ----------------------------------------------------------------------------
// Battery meter digit stages
// Three register stages that take the volts value and the percent apart into
// decimal digits with reciprocal multiplies, two of them in the first stage.
// ----------------------------------------------------------------------------
module bmd_digits
   import bmd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic      s2_valid_ff, s3_valid_ff, s4_valid_ff;
   stage_type s2_data_ff, s3_data_ff, s4_data_ff;
   stage_type s2_data_in, s3_data_in, s4_data_in;
   logic      s2_adv, s3_adv, s4_adv;
   logic [15:0] s3_rem, s4_rem;

   // Each stage moves when it is empty or the next one takes its item.
   assign s4_adv   = !s4_valid_ff || out_ready;
   assign s3_adv   = !s3_valid_ff || s4_adv;
   assign s2_adv   = !s2_valid_ff || s3_adv;
   assign in_ready = s2_adv;

   // Stage two: volts over ten and the percent tens digit.
   always_comb begin
      s2_data_in        = in_data;
      s2_data_in.q1     = 11'(div10({1'b0, in_data.vr}));
      s2_data_in.p_tens = 4'(div10({9'd0, in_data.pct}));
   end

   // Stage three: volts over a hundred and the percent ones digit.
   always_comb begin
      s3_data_in        = s2_data_ff;
      s3_data_in.q2     = 8'(div10({5'd0, s2_data_ff.q1}));
      s3_rem            = {9'd0, s2_data_ff.pct} - mul10({12'd0, s2_data_ff.p_tens});
      s3_data_in.p_ones = s3_rem[3:0];
   end

   // Stage four: volts over a thousand and the tens digit of the volts value.
   always_comb begin
      s4_data_in        = s3_data_ff;
      s4_data_in.q3     = 5'(div10({8'd0, s3_data_ff.q2}));
      s4_rem            = {5'd0, s3_data_ff.q1} - mul10({8'd0, s3_data_ff.q2});
      s4_data_in.d_tens = s4_rem[3:0];
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s2_adv) begin
            s2_valid_ff <= in_valid;
         end
         if (s3_adv) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_adv) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Payload of the three stages.
   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_data_ff <= s2_data_in;
      end
      if (s3_adv) begin
         s3_data_ff <= s3_data_in;
      end
      if (s4_adv) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

>>> rtl/bmd_encode.sv
// ----------------------------------------------------------------------------
// Battery meter encoder stage
// Finishes the volts digits, maps digits to segments, adds marks and level
// bars, and holds the display word in the output register.
// ----------------------------------------------------------------------------
module bmd_encode
   import bmd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   bmd_rsp_if.source rsp_chan
);

   logic                 valid_ff;
   logic [DISPLAY_W-1:0] display_ff;
   logic                 error_ff;
   logic [DISPLAY_W-1:0] display_in;
   logic                 advance;
   logic [15:0]          hund_rem;
   logic [3:0]           d_hund;
   logic [4:0]           d_thou;

   assign advance  = !valid_ff || rsp_chan.ready;
   assign in_ready = advance;

   // Compose the display word.
   always_comb begin
      hund_rem = {8'd0, in_data.q2} - mul10({11'd0, in_data.q3});
      d_hund   = hund_rem[3:0];
      d_thou   = (in_data.q3 >= 5'd10) ? in_data.q3 - 5'd10 : in_data.q3;
      display_in = '0;
      if (in_data.pct_mode) begin
         display_in[PCT_MARK_POS] = 1'b1;
         if (in_data.pct == PCT_MAX) begin
            display_in[DIGIT_L_POS +: 7] = seg(4'd1);
            display_in[DIGIT_M_POS +: 7] = seg(4'd0);
            display_in[DIGIT_R_POS +: 7] = seg(4'd0);
         end else if (in_data.pct >= PCT_TEN) begin
            display_in[DIGIT_M_POS +: 7] = seg(in_data.p_tens);
            display_in[DIGIT_R_POS +: 7] = seg(in_data.p_ones);
         end else begin
            display_in[DIGIT_R_POS +: 7] = seg(in_data.p_ones);
         end
      end else begin
         display_in[VOLT_MARK_POS]    = 1'b1;
         display_in[POINT_POS]        = 1'b1;
         display_in[DIGIT_L_POS +: 7] = seg(d_thou[3:0]);
         display_in[DIGIT_M_POS +: 7] = seg(d_hund);
         display_in[DIGIT_R_POS +: 7] = seg(in_data.d_tens);
      end
      display_in[BAR_POS +: 5] = bar_mask(in_data.pct);
      if (in_data.neg) begin
         display_in = '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         display_ff <= display_in;
         error_ff   <= in_data.neg;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.display_bits = display_ff;
   assign rsp_chan.error        = error_ff;

endmodule

>>> rtl/battery_meter_display.sv
// ----------------------------------------------------------------------------
// Battery meter display
// Turns signed voltage readings into seven-segment display words with a
// percent or volts readout and level bars.
// ----------------------------------------------------------------------------
// The block takes one reading per clock cycle unless a display-side stall
// has filled every stage; it has five register stages (input conversion,
// three digit stages built around reciprocal multiplies, and the output
// register), and every stage holds its item while the next one is full, so a
// stall on the display side backs up without loss and the reading side stays
// ready as long as any stage is free. A negative reading returns the error
// flag with an all-zero display word, which the display must not take.
module battery_meter_display
   import bmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bmd_req_if.sink    req_chan,
   bmd_rsp_if.source  rsp_chan
);

   logic      front_valid, front_ready;
   stage_type front_data;
   logic      dig_valid, dig_ready;
   stage_type dig_data;

   // Reading conversion.
   bmd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // Decimal digit extraction.
   bmd_digits u_digits (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (dig_valid),
      .out_ready (dig_ready),
      .out_data  (dig_data)
   );

   // Segment encoding and output register.
   bmd_encode u_encode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (dig_valid),
      .in_ready (dig_ready),
      .in_data  (dig_data),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/bmd_checker.sv
// ----------------------------------------------------------------------------
// Battery meter display checker
// Port-level assertions on the display channel, bound to the top level.
// ----------------------------------------------------------------------------
module bmd_checker
   import bmd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DISPLAY_W-1:0] rsp_display_bits,
   input logic                 rsp_error
);

   // An error item carries a blank display word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_display_bits == '0)
      else $error("error item with nonzero display word");

   // A good item is either percent mode or volts mode with the point lit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |->
         (rsp_display_bits[PCT_MARK_POS] != rsp_display_bits[VOLT_MARK_POS]) &&
         (rsp_display_bits[VOLT_MARK_POS] == rsp_display_bits[POINT_POS]))
      else $error("display mode marks inconsistent");

   // Level bars always fill from the bottom.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_display_bits[BAR_POS +: 5] == 5'b00000 ||
         rsp_display_bits[BAR_POS +: 5] == 5'b00001 ||
         rsp_display_bits[BAR_POS +: 5] == 5'b00011 ||
         rsp_display_bits[BAR_POS +: 5] == 5'b00111 ||
         rsp_display_bits[BAR_POS +: 5] == 5'b01111 ||
         rsp_display_bits[BAR_POS +: 5] == 5'b11111)
      else $error("level bars not a thermometer code");

   // A stalled item stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_display_bits) && $stable(rsp_error))
      else $error("stalled item changed or dropped");

endmodule

bind battery_meter_display bmd_checker u_bmd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_display_bits (rsp_chan.display_bits),
   .rsp_error        (rsp_chan.error)
);
